@@ hw/rtl/ranged_average_pid_servo_macros.svh @@
// ---------------------------------------------------------------------------
// ranged_average_pid_servo_macros.svh
// Assertion helpers shared by the servo controller RTL.
// ---------------------------------------------------------------------------
`ifndef RANGED_AVERAGE_PID_SERVO_MACROS_SVH
`define RANGED_AVERAGE_PID_SERVO_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RAPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo controller assertion failed");

// next-cycle implication, disabled while in reset
`define RAPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo controller assertion failed");

`endif

@@ hw/rtl/raps_pkg.sv @@
// ---------------------------------------------------------------------------
// raps_pkg
// Shared types and constants of the ranged average PID servo controller.
// ---------------------------------------------------------------------------
`default_nettype none

package raps_pkg;

    // echo conversion: distance = floor(echo * 256 / 58) in 1/256 cm
    localparam logic [13:0] ECHO_CAP   = 14'd10000;
    localparam int          RAW_W      = 16;
    localparam int          RAW_MAX    = 10000 * 256 / 58;
    // ceil(2^28 / 58); echo * 256 * recip >> 28 == echo * recip >> 20
    localparam logic [22:0] DIST_RECIP = 23'd4628198;
    localparam int          DIST_SHIFT = 20;

    // pid fixed point
    localparam int FRAC_SHIFT = 20;
    localparam int ERR_W      = 15;
    localparam int INTEG_W    = 32;
    localparam int WIDE_W     = 18;
    localparam logic signed [WIDE_W-1:0] ERR_HI = 18'sd16383;
    localparam logic signed [WIDE_W-1:0] ERR_LO = -18'sd16384;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 19;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_KP       = 3'd1,
        REG_KI       = 3'd2,
        REG_KD       = 3'd3,
        REG_BASE     = 3'd4,
        REG_OUT_MAX  = 3'd5,
        REG_OUT_MIN  = 3'd6,
        REG_DLIMIT   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        [13:0] setpoint;
        logic signed [18:0] kp;
        logic signed [18:0] ki;
        logic signed [18:0] kd;
        logic        [11:0] base;
        logic        [11:0] omax;
        logic        [11:0] omin;
        logic        [11:0] dlimit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        14'd5120, -19'sd34611, -19'sd229, -19'sd194560,
        12'd1150, 12'd1300, 12'd900, 12'd100
    };

    // load strobes for the pid stages
    typedef struct packed {
        logic upd;
        logic prod_ld;
        logic part_ld;
        logic out_ld;
    } pid_ctl_t;

    // largest distance code for a given range limit in cm
    function automatic int dist_top(input int max_cm);
        int cap;
        cap = max_cm * 256;
        return (cap < RAW_MAX) ? cap : RAW_MAX;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/raps_range.sv @@
// ---------------------------------------------------------------------------
// raps_range
// Echo input register and echo time to distance conversion stage.
// ---------------------------------------------------------------------------
`default_nettype none

module raps_range #(
    parameter int MAX_DISTANCE_CM = 38,
    parameter int DIST_W          = 14
) (
    input  wire logic              clk,
    input  wire logic              ld_echo,
    input  wire logic              ld_dist,
    input  wire logic [13:0]       echo,
    output logic      [DIST_W-1:0] dist_code
);
    import raps_pkg::*;

    localparam int DIST_TOP = dist_top(MAX_DISTANCE_CM);
    localparam int PROD_W   = 14 + 23;

    logic [13:0]       echo_reg;
    logic [13:0]       echo_c;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  raw;
    logic [DIST_W-1:0] dist_next;
    logic [DIST_W-1:0] dist_reg;

    // input register
    always_ff @(posedge clk)
    begin
        if (ld_echo)
        begin
            echo_reg <= echo;
        end
    end

    // cap echo, divide by 58 through reciprocal, clamp to range
    always_comb
    begin
        echo_c = (echo_reg > ECHO_CAP) ? ECHO_CAP : echo_reg;
        prod   = PROD_W'(echo_c) * PROD_W'(DIST_RECIP);
        raw    = prod[DIST_SHIFT +: RAW_W];
        if (raw > RAW_W'(DIST_TOP))
        begin
            dist_next = DIST_W'(DIST_TOP);
        end
        else
        begin
            dist_next = DIST_W'(raw);
        end
    end

    // distance register
    always_ff @(posedge clk)
    begin
        if (ld_dist)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_code = dist_reg;

endmodule

`default_nettype wire

@@ hw/rtl/raps_ring.sv @@
// ---------------------------------------------------------------------------
// raps_ring
// Sample ring with running sum and divide-by-window average stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ranged_average_pid_servo_macros.svh"

module raps_ring #(
    parameter int WINDOW_SIZE     = 5,
    parameter int MAX_DISTANCE_CM = 38,
    parameter int DIST_W          = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              ld_avg,
    input  wire logic [DIST_W-1:0] dist_code,
    output logic      [DIST_W-1:0] avg
);
    import raps_pkg::*;

    localparam int    DIST_TOP = dist_top(MAX_DISTANCE_CM);
    localparam int    POS_W    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int    SUM_W    = $clog2(WINDOW_SIZE * DIST_TOP + 1);
    localparam int    AVG_L    = $clog2(WINDOW_SIZE);
    localparam int    AVG_S    = SUM_W + AVG_L;
    localparam int    PROD_W   = 2 * SUM_W + 1;
    // exact reciprocal: floor(sum * m / 2^AVG_S) == floor(sum / window)
    localparam longint AVG_M_L =
        ((64'sd1 <<< AVG_S) + longint'(WINDOW_SIZE) - 64'sd1) / longint'(WINDOW_SIZE);
    localparam logic [63:0] AVG_M_V = 64'(AVG_M_L);
    localparam logic [SUM_W:0] AVG_M = AVG_M_V[SUM_W:0];

    logic [DIST_W-1:0] ring_reg [WINDOW_SIZE];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] avg_reg;

    // running sum: drop the overwritten sample, add the new one
    always_comb
    begin
        sum_next = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(dist_code);
        if (pos_reg == POS_W'(WINDOW_SIZE - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // ring state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (push)
        begin
            ring_reg[pos_reg] <= dist_code;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
        end
    end

    // average by reciprocal multiply
    assign prod = PROD_W'(sum_reg) * PROD_W'(AVG_M);

    always_ff @(posedge clk)
    begin
        if (ld_avg)
        begin
            avg_reg <= prod[AVG_S +: DIST_W];
        end
    end

    assign avg = avg_reg;

    `RAPS_ASSERT_IMPL(a_pos_in_window, clk, rst_n, 1'b1, pos_reg <= POS_W'(WINDOW_SIZE - 1))

endmodule

`default_nettype wire

@@ hw/rtl/raps_pid.sv @@
// ---------------------------------------------------------------------------
// raps_pid
// Error and integral update, PID products, derivative clamp and pulse clamp.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ranged_average_pid_servo_macros.svh"

module raps_pid #(
    parameter int DIST_W = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire raps_pkg::pid_ctl_t ctl,
    input  wire raps_pkg::cfg_t    cfg,
    input  wire logic [DIST_W-1:0] avg,
    output logic      [11:0]       servo_pulse,
    output logic      [13:0]       avg_out
);
    import raps_pkg::*;

    localparam int P_W   = 19 + ERR_W;
    localparam int I_W   = 19 + INTEG_W;
    localparam int D_W   = 19 + ERR_W + 1;
    localparam int DC_W  = 33;
    localparam int PI_W  = I_W + 1;
    localparam int TOT_W = PI_W + 1;
    localparam logic [FRAC_SHIFT-1:0] FRAC_ZERO = '0;

    // error stage
    logic signed [WIDE_W-1:0]  diff;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ERR_W:0]     derr_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W:0]     derr_reg;
    logic        [13:0]        avg4_reg;

    // product stage
    logic signed [P_W-1:0] p_reg;
    logic signed [I_W-1:0] i_reg;
    logic signed [D_W-1:0] d_reg;
    logic        [13:0]    avg5_reg;

    // partial sum stage
    logic signed [D_W-1:0]  dlim_p;
    logic signed [D_W-1:0]  dlim_n;
    logic signed [D_W-1:0]  dc_full;
    logic signed [PI_W-1:0] pi_next;
    logic signed [PI_W-1:0] pi_reg;
    logic signed [DC_W-1:0] dc_reg;
    logic        [13:0]     avg6_reg;

    // output stage
    logic signed [TOT_W-1:0] total;
    logic signed [TOT_W-1:0] hi;
    logic signed [TOT_W-1:0] lo;
    logic signed [TOT_W-1:0] t_hi;
    logic signed [TOT_W-1:0] t_cl;
    logic        [11:0]      servo_reg;
    logic        [13:0]      avg_out_reg;

    // error, saturated integral, error difference
    always_comb
    begin
        diff = $signed(WIDE_W'(cfg.setpoint)) - $signed(WIDE_W'(avg));
        if (diff > ERR_HI)
        begin
            err_next = ERR_W'(ERR_HI);
        end
        else if (diff < ERR_LO)
        begin
            err_next = ERR_W'(ERR_LO);
        end
        else
        begin
            err_next = diff[ERR_W-1:0];
        end

        integ_sum = $signed({integ_reg[INTEG_W-1], integ_reg})
                  + $signed({{(INTEG_W + 1 - ERR_W){err_next[ERR_W-1]}}, err_next});
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end

        derr_next = $signed({err_next[ERR_W-1], err_next})
                  - $signed({err_reg[ERR_W-1], err_reg});
    end

    // integral and previous error live in the error stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg   <= '0;
            integ_reg <= '0;
        end
        else if (ctl.upd)
        begin
            err_reg   <= err_next;
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.upd)
        begin
            derr_reg <= derr_next;
            avg4_reg <= 14'(avg);
        end
    end

    // pid products
    always_ff @(posedge clk)
    begin
        if (ctl.prod_ld)
        begin
            p_reg    <= $signed(cfg.kp) * err_reg;
            i_reg    <= $signed(cfg.ki) * integ_reg;
            d_reg    <= $signed(cfg.kd) * derr_reg;
            avg5_reg <= avg4_reg;
        end
    end

    // derivative clamp and proportional plus integral
    always_comb
    begin
        dlim_p = $signed({{(D_W - 12 - FRAC_SHIFT){1'b0}}, cfg.dlimit, FRAC_ZERO});
        dlim_n = -dlim_p;
        if (d_reg > dlim_p)
        begin
            dc_full = dlim_p;
        end
        else if (d_reg < dlim_n)
        begin
            dc_full = dlim_n;
        end
        else
        begin
            dc_full = d_reg;
        end
        pi_next = $signed({{(PI_W - P_W){p_reg[P_W-1]}}, p_reg})
                + $signed({i_reg[I_W-1], i_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.part_ld)
        begin
            pi_reg   <= pi_next;
            dc_reg   <= dc_full[DC_W-1:0];
            avg6_reg <= avg5_reg;
        end
    end

    // final sum, clamp to max then min
    always_comb
    begin
        total = $signed({{(TOT_W - 12 - FRAC_SHIFT){1'b0}}, cfg.base, FRAC_ZERO})
              + $signed({pi_reg[PI_W-1], pi_reg})
              + $signed({{(TOT_W - DC_W){dc_reg[DC_W-1]}}, dc_reg});
        hi    = $signed({{(TOT_W - 12 - FRAC_SHIFT){1'b0}}, cfg.omax, FRAC_ZERO});
        lo    = $signed({{(TOT_W - 12 - FRAC_SHIFT){1'b0}}, cfg.omin, FRAC_ZERO});
        t_hi  = (total > hi) ? hi : total;
        t_cl  = (t_hi < lo) ? lo : t_hi;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.out_ld)
        begin
            servo_reg   <= t_cl[FRAC_SHIFT +: 12];
            avg_out_reg <= avg6_reg;
        end
    end

    assign servo_pulse = servo_reg;
    assign avg_out     = avg_out_reg;

    `RAPS_ASSERT_NEXT(a_pulse_in_bounds, clk, rst_n, ctl.out_ld && (cfg.omin <= cfg.omax), (servo_reg >= cfg.omin) && (servo_reg <= cfg.omax))

endmodule

`default_nettype wire

@@ hw/rtl/ranged_average_pid_servo.sv @@
// ---------------------------------------------------------------------------
// ranged_average_pid_servo
// Echo time to servo pulse controller: range, moving average and PID.
// ---------------------------------------------------------------------------
// The block takes one echo time per transfer and returns one result per
// transfer (servo pulse width and window average), in order. It is an
// eight-stage pipeline: input register, distance, ring sum, average, error
// and integral, PID products, partial sums, result register, and a new echo
// can be taken every cycle while the output is not stalled. Each stage holds
// its own valid bit; a stall at the output only backs up into stages that
// are occupied, so bubbles are squeezed out and the input stalls only when
// every stage holds an item. The ring and the integral
// are updated as an item moves through the ring and error stages, which keeps
// consecutive items exact at full rate. Configuration writes take effect at
// once and must be made while no item is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ranged_average_pid_servo_macros.svh"

module ranged_average_pid_servo #(
    parameter int WINDOW_SIZE     = 5,
    parameter int MAX_DISTANCE_CM = 38
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [13:0]                          echo_time_us,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic      [11:0]                          servo_pulse_us,
    output logic      [13:0]                          average_distance,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [raps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [raps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import raps_pkg::*;

    localparam int NST      = 8;
    localparam int DIST_TOP = dist_top(MAX_DISTANCE_CM);
    localparam int DIST_W   = $clog2(DIST_TOP + 1);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [NST-1:0]   v_reg;
    logic [NST-1:0]   v_next;
    logic [NST-1:0]   go;
    pid_ctl_t         pid_ctl;
    logic [DIST_W-1:0] dist_code;
    logic [DIST_W-1:0] avg;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SETPOINT: cfg_next.setpoint = cfg_data[13:0];
                REG_KP:       cfg_next.kp       = $signed(cfg_data);
                REG_KI:       cfg_next.ki       = $signed(cfg_data);
                REG_KD:       cfg_next.kd       = $signed(cfg_data);
                REG_BASE:     cfg_next.base     = cfg_data[11:0];
                REG_OUT_MAX:  cfg_next.omax     = cfg_data[11:0];
                REG_OUT_MIN:  cfg_next.omin     = cfg_data[11:0];
                REG_DLIMIT:   cfg_next.dlimit   = cfg_data[11:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stage advance: a stage loads when empty or when the next one loads
    always_comb
    begin
        go[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            go[k] = !v_reg[k] || go[k+1];
        end
        v_next[0] = go[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            v_next[k] = go[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !go[0];
    assign out_valid = v_reg[NST-1];

    // pid stage strobes
    assign pid_ctl.upd     = go[4] && v_reg[3];
    assign pid_ctl.prod_ld = go[5];
    assign pid_ctl.part_ld = go[6];
    assign pid_ctl.out_ld  = go[7] && v_reg[6];

    raps_range #(
        .MAX_DISTANCE_CM (MAX_DISTANCE_CM),
        .DIST_W          (DIST_W)
    ) u_range (
        .clk       (clk),
        .ld_echo   (go[0]),
        .ld_dist   (go[1]),
        .echo      (echo_time_us),
        .dist_code (dist_code)
    );

    raps_ring #(
        .WINDOW_SIZE     (WINDOW_SIZE),
        .MAX_DISTANCE_CM (MAX_DISTANCE_CM),
        .DIST_W          (DIST_W)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (go[2] && v_reg[1]),
        .ld_avg    (go[3]),
        .dist_code (dist_code),
        .avg       (avg)
    );

    raps_pid #(
        .DIST_W (DIST_W)
    ) u_pid (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (pid_ctl),
        .cfg         (cfg_reg),
        .avg         (avg),
        .servo_pulse (servo_pulse_us),
        .avg_out     (average_distance)
    );

    `RAPS_ASSERT_IMPL(a_stall_only_when_occupied, clk, rst_n, in_stall, v_reg[0])
    `RAPS_ASSERT_IMPL(a_full_and_blocked_stalls, clk, rst_n, (&v_reg) && out_stall, in_stall)

endmodule

`default_nettype wire

@@ tb/sv/ranged_average_pid_servo_test.sv @@
// ----------------------------------------------------------------------------
// ranged_average_pid_servo_test
// Self-checking bench for the echo-to-servo PID controller.
// Echo times go in over the valid/stall channel and results come back on the
// output channel. An in-bench predictor tracks the distance ring, the error
// integral and the previous error. It predicts pulse width and average for
// every transfer, and each result is compared with the oldest prediction.
// Directed items cover field extremes, register extremes, min above max and
// the derivative clamp. Random phases follow with random settings and idling.
// The run ends with a clean full-rate burst.
// ----------------------------------------------------------------------------
`default_nettype none

module ranged_average_pid_servo_test;
    import raps_pkg::*;

    localparam int     WINDOW_LEN  = 5;
    localparam int     RANGE_CM    = 38;
    localparam int     CM_DIVISOR  = 58;
    localparam longint INTEG_MAX   = 64'sd2147483647;
    localparam longint INTEG_MIN   = -64'sd2147483648;
    localparam int     MAX_REPORTS = 10;

    typedef struct {
        logic [11:0] pulse;
        logic [13:0] average;
    } servo_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [13:0]            echo_time_us;
    logic                   out_valid;
    logic                   out_stall;
    logic [11:0]            servo_pulse_us;
    logic [13:0]            average_distance;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    cfg_t          servo_cfg;
    logic [13:0]   ring_dist [WINDOW_LEN];
    int            ring_pos;
    longint        error_sum;
    longint        prior_error;
    servo_result_t expected_results[$];

    int mismatch_count;
    bit gaps_on;
    bit stall_on;

    ranged_average_pid_servo #(
        .WINDOW_SIZE     (WINDOW_LEN),
        .MAX_DISTANCE_CM (RANGE_CM)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .echo_time_us     (echo_time_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .servo_pulse_us   (servo_pulse_us),
        .average_distance (average_distance),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // servo update for one echo: range, ring average, pid, output clamp
    function automatic servo_result_t predict_servo(input logic [13:0] echo);
        longint        echo_c;
        longint        dist_cm;
        longint        ring_total;
        longint        avg;
        longint        err;
        longint        gain;
        longint        p_term;
        longint        i_term;
        longint        d_term;
        longint        d_lim;
        longint        total;
        longint        hi;
        longint        lo;
        servo_result_t r;
        echo_c = longint'(echo);
        if (echo_c > longint'(ECHO_CAP))
            echo_c = longint'(ECHO_CAP);
        dist_cm = (echo_c * 256) / CM_DIVISOR;
        if (dist_cm > longint'(RANGE_CM * 256))
            dist_cm = longint'(RANGE_CM * 256);
        ring_dist[ring_pos] = 14'(dist_cm);
        ring_pos = (ring_pos + 1) % WINDOW_LEN;
        ring_total = 0;
        for (int k = 0; k < WINDOW_LEN; k++)
            ring_total += longint'(ring_dist[k]);
        avg = ring_total / WINDOW_LEN;
        // error saturates to 15-bit signed
        err = longint'(servo_cfg.setpoint) - avg;
        if (err > 16383)
            err = 16383;
        if (err < -16384)
            err = -16384;
        error_sum += err;
        if (error_sum > INTEG_MAX)
            error_sum = INTEG_MAX;
        if (error_sum < INTEG_MIN)
            error_sum = INTEG_MIN;
        gain = $signed(servo_cfg.kp);
        p_term = gain * err;
        gain = $signed(servo_cfg.ki);
        i_term = gain * error_sum;
        gain = $signed(servo_cfg.kd);
        d_term = gain * (err - prior_error);
        d_lim = longint'(servo_cfg.dlimit) << FRAC_SHIFT;
        if (d_term > d_lim)
            d_term = d_lim;
        if (d_term < -d_lim)
            d_term = -d_lim;
        prior_error = err;
        // max clamp first, min clamp last
        total = (longint'(servo_cfg.base) << FRAC_SHIFT) + p_term + i_term + d_term;
        hi = longint'(servo_cfg.omax) << FRAC_SHIFT;
        lo = longint'(servo_cfg.omin) << FRAC_SHIFT;
        if (total > hi)
            total = hi;
        if (total < lo)
            total = lo;
        r.pulse = 12'(total >>> FRAC_SHIFT);
        r.average = 14'(avg);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %0d at %0t: %s expected %0d got %0d",
                     mismatch_count, $realtime, what, want, got);
    endtask

    // one echo transfer; called at a falling edge, returns at a falling edge
    task automatic send_echo(input logic [13:0] echo);
        in_valid <= 1'b1;
        echo_time_us <= echo;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_servo(echo));
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    // drain the pipeline, then write all eight registers back to back
    task automatic load_config(input cfg_t c);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        // unused upper data bits carry junk, the block must mask them
        write_reg(REG_SETPOINT, {5'($urandom), c.setpoint});
        write_reg(REG_KP, c.kp);
        write_reg(REG_KI, c.ki);
        write_reg(REG_KD, c.kd);
        write_reg(REG_BASE, {7'($urandom), c.base});
        write_reg(REG_OUT_MAX, {7'($urandom), c.omax});
        write_reg(REG_OUT_MIN, {7'($urandom), c.omin});
        write_reg(REG_DLIMIT, {7'($urandom), c.dlimit});
        cfg_wr_en <= 1'b0;
        servo_cfg = c;
    endtask

    function automatic logic [13:0] random_echo();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 14'($urandom_range(0, 2300));
        else if (pick < 17)
            return 14'($urandom_range(0, 10000));
        return 14'($urandom);
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.setpoint = ($urandom_range(0, 9) == 0) ? 14'($urandom)
                                                  : 14'($urandom_range(0, 9728));
        c.kp = $signed(19'($urandom)) >>> $urandom_range(0, 12);
        c.ki = $signed(19'($urandom)) >>> $urandom_range(4, 18);
        c.kd = $signed(19'($urandom)) >>> $urandom_range(0, 12);
        if ($urandom_range(0, 4) == 0)
        begin
            // anything goes, min above max included
            c.base = 12'($urandom);
            c.omax = 12'($urandom);
            c.omin = 12'($urandom);
        end
        else
        begin
            c.base = 12'($urandom_range(800, 3200));
            c.omax = 12'(c.base + $urandom_range(0, 800));
            c.omin = 12'(c.base - $urandom_range(0, 800));
        end
        c.dlimit = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 400));
        return c;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        servo_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                note_mismatch("result with none expected", 0, 32'(servo_pulse_us));
            else
            begin
                want = expected_results.pop_front();
                if (servo_pulse_us !== want.pulse)
                    note_mismatch("servo_pulse_us", 32'(want.pulse), 32'(servo_pulse_us));
                if (average_distance !== want.average)
                    note_mismatch("average_distance", 32'(want.average),
                                  32'(average_distance));
            end
        end
    end

    // output stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // echo range edges under reset settings
    task automatic test_reset_settings();
        send_echo(14'd0);
        send_echo(14'd58);
        send_echo(14'd2205);
        send_echo(14'd9999);
        send_echo(14'd10000);
        send_echo(14'd10001);
        send_echo(14'd16383);
        send_echo(14'd57);
    endtask

    // every register at its top, then at its bottom
    task automatic test_register_extremes();
        cfg_t c;
        c = '{14'd16383, 19'sd262143, 19'sd262143, 19'sd262143,
              12'd4095, 12'd4095, 12'd4095, 12'd4095};
        load_config(c);
        send_echo(14'd0);
        send_echo(14'd16383);
        send_echo(14'd0);
        send_echo(14'd1000);
        c = '{14'd0, -19'sd262144, -19'sd262144, -19'sd262144,
              12'd0, 12'd0, 12'd0, 12'd0};
        load_config(c);
        send_echo(14'd16383);
        send_echo(14'd0);
        send_echo(14'd16383);
        send_echo(14'd5000);
    endtask

    // minimum above maximum: the pulse must sit at the minimum
    task automatic test_min_above_max();
        cfg_t c;
        c = '{14'd5120, -19'sd34611, -19'sd229, -19'sd1000,
              12'd1200, 12'd1000, 12'd1500, 12'd100};
        load_config(c);
        send_echo(14'd0);
        send_echo(14'd2000);
        send_echo(14'd700);
        send_echo(14'd16383);
    endtask

    // large error swings against a tight derivative clamp
    task automatic test_derivative_clamp();
        cfg_t c;
        c = '{14'd4000, 19'sd0, 19'sd0, -19'sd262144,
              12'd2000, 12'd4095, 12'd0, 12'd3};
        load_config(c);
        send_echo(14'd16383);
        send_echo(14'd0);
        send_echo(14'd16383);
        send_echo(14'd0);
    endtask

    // random settings per phase, idling varies, last phase runs clean
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            load_config(random_config());
            gaps_on = (phase != 1) && (phase < 5);
            stall_on = (phase != 2) && (phase < 5);
            repeat (230) send_echo(random_echo());
        end
    endtask

    // back to back transfers with no idling on either side
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        stall_on = 1'b0;
        repeat (48) send_echo(random_echo());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        echo_time_us = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SETPOINT;
        cfg_data = '0;
        servo_cfg = CFG_RESET;
        for (int k = 0; k < WINDOW_LEN; k++)
            ring_dist[k] = '0;
        ring_pos = 0;
        error_sum = 0;
        prior_error = 0;
        mismatch_count = 0;
        gaps_on = 1'b1;
        stall_on = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_register_extremes();
        test_min_above_max();
        test_derivative_clamp();
        test_random_traffic();
        test_back_to_back();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS ranged_average_pid_servo");
        else
            $display("FAIL ranged_average_pid_servo");
        $finish;
    end

    // run limit
    initial
    begin
        #30000000;
        $display("FAIL ranged_average_pid_servo");
        $finish;
    end

endmodule

`default_nettype wire

@@ ranged_average_pid_servo.f @@
+incdir+hw/rtl
hw/rtl/raps_pkg.sv
hw/rtl/raps_range.sv
hw/rtl/raps_ring.sv
hw/rtl/raps_pid.sv
hw/rtl/ranged_average_pid_servo.sv
tb/sv/ranged_average_pid_servo_test.sv
